### rtl/bdasc_pkg.sv
// Shared types and constants for the signed binary to decimal ASCII converter.
package bdasc_pkg;

    // ASCII codes, trimmed to the 6-bit character port
    localparam logic [5:0] CHAR_ZERO  = 6'd48;
    localparam logic [5:0] CHAR_MINUS = 6'd45;

    // Shift-add-3 digit correction
    localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
    localparam logic [3:0] BCD_ADJ     = 4'd3;

    // log10(2) ~= 1233 / 2^12, used to size the digit buffer at elaboration
    localparam int LOG10_2_NUM   = 1233;
    localparam int LOG10_2_SHIFT = 12;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SCAN,
        ST_EMIT
    } back_state_t;

endpackage

### rtl/bdasc_front.sv
// Front end: input register, sign detection and magnitude forming.
module bdasc_front #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [VALUE_WIDTH-1:0] s_value,
    output logic                   push_valid,
    input  logic                   push_ready,
    output logic                   push_neg,
    output logic [VALUE_WIDTH-1:0] push_mag
);
    import bdasc_pkg::*;

    logic                   vld_reg;
    logic                   vld_next;
    logic [VALUE_WIDTH-1:0] value_reg;

    assign s_ready    = !vld_reg || push_ready;
    assign push_valid = vld_reg;
    assign push_neg   = value_reg[VALUE_WIDTH-1];
    // unsigned negate: the most negative value maps to 2^(W-1)
    assign push_mag   = push_neg ? (~value_reg + VALUE_WIDTH'(1)) : value_reg;

    always_comb begin
        vld_next = vld_reg;
        if (s_valid && s_ready) begin
            vld_next = 1'b1;
        end else if (push_ready) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            value_reg <= s_value;
        end
    end

endmodule

### rtl/bdasc_queue.sv
// Two-entry queue of classified transactions between front and back end.
module bdasc_queue #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push_valid,
    output logic                   push_ready,
    input  logic                   push_neg,
    input  logic [VALUE_WIDTH-1:0] push_mag,
    output logic                   pop_valid,
    input  logic                   pop_ready,
    output logic                   pop_neg,
    output logic [VALUE_WIDTH-1:0] pop_mag
);
    import bdasc_pkg::*;

    logic [VALUE_WIDTH:0] mem [2];
    logic                 wr_ptr_reg;
    logic                 wr_ptr_next;
    logic                 rd_ptr_reg;
    logic                 rd_ptr_next;
    logic [1:0]           count_reg;
    logic [1:0]           count_next;
    logic                 push;
    logic                 pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign {pop_neg, pop_mag} = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= {push_neg, push_mag};
        end
    end

endmodule

### rtl/bdasc_back.sv
// Back end: shift-add-3 conversion to BCD, then one character per cycle while the output is not stalled.
module bdasc_back #(
    parameter int VALUE_WIDTH = 32,
    parameter int NUM_DIGITS  = 10
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   q_valid,
    output logic                   q_ready,
    input  logic                   q_neg,
    input  logic [VALUE_WIDTH-1:0] q_mag,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [5:0]             m_ascii_char,
    output logic                   m_is_last
);
    import bdasc_pkg::*;

    localparam int CNT_W = $clog2(VALUE_WIDTH);
    localparam int POS_W = $clog2(NUM_DIGITS);
    localparam int BCD_W = NUM_DIGITS * 4;

    back_state_t state_reg, state_next;

    logic [VALUE_WIDTH-1:0]     mag_reg, mag_next;
    logic [NUM_DIGITS-1:0][3:0] bcd_reg, bcd_next;
    logic [NUM_DIGITS-1:0][3:0] bcd_adj;
    logic [BCD_W-1:0]           bcd_flat;
    logic [BCD_W-1:0]           bcd_shift;
    logic                       neg_reg, neg_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [POS_W-1:0]           pos_reg, pos_next;
    logic [POS_W-1:0]           top_digit;
    logic                       m_valid_reg, m_valid_next;
    logic [5:0]                 m_char_reg, m_char_next;
    logic                       m_is_last_reg, m_is_last_next;
    logic                       out_free;

    assign m_valid      = m_valid_reg;
    assign m_ascii_char = m_char_reg;
    assign m_is_last    = m_is_last_reg;

    always_comb begin
        // add 3 to every digit of 5 or more, then shift in the next bit
        for (int i = 0; i < NUM_DIGITS; i++) begin
            bcd_adj[i] = (bcd_reg[i] >= BCD_ADJ_MIN) ? (bcd_reg[i] + BCD_ADJ) : bcd_reg[i];
        end
        bcd_flat  = bcd_adj;
        bcd_shift = {bcd_flat[BCD_W-2:0], mag_reg[VALUE_WIDTH-1]};

        // highest nonzero digit; zero leaves the units digit
        top_digit = '0;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (bcd_reg[i] != 4'd0) begin
                top_digit = POS_W'(i);
            end
        end

        out_free = !m_valid_reg || m_ready;

        state_next     = state_reg;
        mag_next       = mag_reg;
        bcd_next       = bcd_reg;
        neg_next       = neg_reg;
        cnt_next       = cnt_reg;
        pos_next       = pos_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_char_next    = m_char_reg;
        m_is_last_next = m_is_last_reg;
        q_ready        = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                q_ready = 1'b1;
                if (q_valid) begin
                    mag_next   = q_mag;
                    neg_next   = q_neg;
                    bcd_next   = '0;
                    cnt_next   = CNT_W'(VALUE_WIDTH - 1);
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                mag_next = mag_reg << 1;
                bcd_next = bcd_shift;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                pos_next   = top_digit;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (neg_reg) begin
                        m_char_next    = CHAR_MINUS;
                        m_is_last_next = 1'b0;
                        neg_next       = 1'b0;
                    end else begin
                        m_char_next    = CHAR_ZERO + {2'b00, bcd_reg[pos_reg]};
                        m_is_last_next = (pos_reg == '0);
                        if (pos_reg == '0) begin
                            state_next = ST_IDLE;
                        end else begin
                            pos_next = pos_reg - POS_W'(1);
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg       <= mag_next;
        bcd_reg       <= bcd_next;
        neg_reg       <= neg_next;
        cnt_reg       <= cnt_next;
        pos_reg       <= pos_next;
        m_char_reg    <= m_char_next;
        m_is_last_reg <= m_is_last_next;
    end

`ifndef SYNTH
    a_start_conv: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && q_valid) |=>
        (state_reg == ST_CONV && cnt_reg == CNT_W'(VALUE_WIDTH - 1)))
        else $error("conversion did not start after queue pop");

    a_conv_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CONV && cnt_reg != '0) |=> (state_reg == ST_CONV))
        else $error("conversion left early");

    a_scan_after_conv: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> ($past(state_reg) == ST_CONV && $past(cnt_reg) == '0))
        else $error("digit scan without finished conversion");

    a_last_char: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && out_free && !neg_reg && pos_reg == '0) |=>
        (state_reg == ST_IDLE && m_valid_reg && m_is_last_reg))
        else $error("units digit not flagged as last");

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> (pos_reg <= POS_W'(NUM_DIGITS - 1)))
        else $error("digit pointer out of range");
`endif

endmodule

### rtl/signed_binary_to_decimal_ascii.sv
// Signed binary to decimal ASCII converter, top level.
// The back end converts one value at a time: a bit-serial shift-add-3 loop, a leading-zero scan,
//   then one character per cycle while the output is not stalled (1..11 characters at 32 bits).
// The front end and a two-entry queue keep accepting values while the back end is busy, until both are full.
// Reset: synchronous, active low; clears all handshake and state control, payload is not reset.
module signed_binary_to_decimal_ascii #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // input channel: one signed value per transaction
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [VALUE_WIDTH-1:0] s_value,
    // result channel: one character per transaction, most significant first
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [5:0]             m_ascii_char,
    output logic                   m_is_last
);
    import bdasc_pkg::*;

    // Decimal digits of 2^(VALUE_WIDTH-1), the largest magnitude (10 at 32 bits, 19 at 64).
    localparam int NUM_DIGITS = (((VALUE_WIDTH - 1) * LOG10_2_NUM) >> LOG10_2_SHIFT) + 1;

    // front end -> queue
    logic                   push_valid;
    logic                   push_ready;
    logic                   push_neg;
    logic [VALUE_WIDTH-1:0] push_mag;

    // queue -> back end
    logic                   pop_valid;
    logic                   pop_ready;
    logic                   pop_neg;
    logic [VALUE_WIDTH-1:0] pop_mag;

    // Front end registers the incoming transaction and splits it into sign and
    // unsigned magnitude, so the most negative value needs no special handling.
    bdasc_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_value    (s_value),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_neg   (push_neg),
        .push_mag   (push_mag)
    );

    // Short queue decouples the front end from the long back end conversion.
    bdasc_queue #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_neg   (push_neg),
        .push_mag   (push_mag),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_neg    (pop_neg),
        .pop_mag    (pop_mag)
    );

    // Back end: one magnitude bit per cycle into BCD, a leading-zero scan,
    // then '-' (if negative) and the significant digits through an output register.
    bdasc_back #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .NUM_DIGITS  (NUM_DIGITS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (pop_valid),
        .q_ready      (pop_ready),
        .q_neg        (pop_neg),
        .q_mag        (pop_mag),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_ascii_char (m_ascii_char),
        .m_is_last    (m_is_last)
    );

endmodule

### test/tb_signed_binary_to_decimal_ascii.sv
// Testbench for the decimal ASCII converter: directed corners, random traffic, backpressure.
module tb_signed_binary_to_decimal_ascii;
    import bdasc_pkg::*;

    localparam int VALUE_WIDTH    = 32;
    localparam int MAX_DIGITS     = 10;             // digits of 2^31
    localparam int MAX_CHARS      = MAX_DIGITS + 1; // plus the sign
    localparam int HOLD_CYCLES    = 400;            // long receiver hold-off
    localparam int WATCHDOG_LIMIT = 4000;           // cycles with no transaction on either side
    localparam int TAIL_CYCLES    = 2 * (VALUE_WIDTH + 3 + MAX_CHARS);
    localparam int RANDOM_PER_PHASE = 50;
    localparam int REPORT_LIMIT   = 10;

    // One expected character on the result channel
    typedef struct packed {
        logic [5:0] ch;
        logic       last;
    } ascii_beat_t;

    // DUT ports; every input starts at a known value
    logic                   aclk         = 1'b0;
    logic                   aresetn      = 1'b0;
    logic                   s_valid      = 1'b0;
    logic                   s_ready;
    logic [VALUE_WIDTH-1:0] s_value      = '0;
    logic                   m_valid;
    logic                   m_ready      = 1'b0;
    logic [5:0]             m_ascii_char;
    logic                   m_is_last;

    // Expected characters, oldest first, across all values in flight
    ascii_beat_t pending_chars[$];
    ascii_beat_t want_beat;

    // Traffic shaping, in percent of cycles
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // Hold-off handshake between the test tasks and the receiver process
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;

    int failures       = 0;
    int values_sent    = 0;
    int chars_checked  = 0;
    int negatives_sent = 0;
    int quiet_cycles   = 0;

    signed_binary_to_decimal_ascii #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_ascii_char(m_ascii_char),
        .m_is_last   (m_is_last)
    );

    // 20-unit clock period
    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // Counts a failure; only the first few get a printed line.
    task automatic note_failure(input string msg);
        failures++;
        if (failures <= REPORT_LIMIT) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    // Predictor: appends the decimal text of one value to pending_chars.
    // The magnitude is formed unsigned at the full width, so the most
    // negative value yields 2^(W-1) with no overflow.
    function automatic void queue_decimal_text(input logic [VALUE_WIDTH-1:0] v);
        logic                   neg;
        logic [VALUE_WIDTH-1:0] mag;
        logic [3:0]             digits[$];
        ascii_beat_t            beat;
        neg = v[VALUE_WIDTH-1];
        mag = neg ? (~v + 1'b1) : v;
        // Least significant digit first; zero still yields one digit
        do begin
            digits.push_back(4'(mag % 10));
            mag = mag / 10;
        end while (mag != 0);
        if (neg) begin
            beat.ch   = CHAR_MINUS;
            beat.last = 1'b0;
            pending_chars.push_back(beat);
        end
        for (int k = digits.size() - 1; k >= 0; k--) begin
            beat.ch   = CHAR_ZERO + {2'b00, digits[k]};
            beat.last = (k == 0);
            pending_chars.push_back(beat);
        end
    endfunction

    // Random value with an even spread of text lengths. A quarter are raw
    // bit patterns, a quarter sit next to a power of ten (digit rollover),
    // the rest have a random digit count and sign.
    function automatic logic [VALUE_WIDTH-1:0] random_value();
        longint unsigned mag;
        longint unsigned span;
        logic [63:0]     wide;
        int              nd;
        logic            neg;
        neg  = 1'($urandom_range(1));
        span = 1;
        case ($urandom_range(3))
            0: begin
                return $urandom;
            end
            1: begin
                nd = $urandom_range(MAX_DIGITS - 1);
                repeat (nd) span = span * 10;
                mag = span + $urandom_range(2) - 1;
            end
            default: begin
                nd = $urandom_range(MAX_DIGITS, 1);
                repeat (nd) span = span * 10;
                mag = {$urandom, $urandom} % span;
            end
        endcase
        // Clamp into the signed range; the most negative value stays reachable
        if (neg && mag > (64'd1 << (VALUE_WIDTH - 1))) begin
            mag = 64'd1 << (VALUE_WIDTH - 1);
        end
        if (!neg && mag > (64'd1 << (VALUE_WIDTH - 1)) - 1) begin
            mag = (64'd1 << (VALUE_WIDTH - 1)) - 1;
        end
        wide = neg ? (~mag + 64'd1) : mag;
        return wide[VALUE_WIDTH-1:0];
    endfunction

    // Sends one value as a single input transaction. An optional idle gap
    // comes first; with no gap, valid stays high straight into the next
    // item so it is never dropped and raised in the same step.
    task automatic send_value(input logic [VALUE_WIDTH-1:0] v);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= v;
        @(posedge aclk);
        // Ports read here still hold their pre-edge values
        while (!s_ready) @(posedge aclk);
        queue_decimal_text(v);
        values_sent++;
        if (v[VALUE_WIDTH-1]) negatives_sent++;
    endtask

    // Drops valid and waits for every expected character to come out.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge aclk);
    endtask

    task automatic set_traffic(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // Extremes of the field, every decimal digit, both
    // signs, the most negative value and zero.
    task automatic test_corner_values();
        logic [VALUE_WIDTH-1:0] corners[21];
        corners = '{
            32'd0, 32'd1, -32'd1, 32'd9, -32'd9, 32'd10, -32'd10, 32'd99, 32'd100,
            -32'd101, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
            32'd1000000000, -32'd1000000000, 32'd999999999,
            32'd1234567890, -32'd1234567890, 32'h5555_5555, 32'hAAAA_AAAA,
            32'h0000_FFFF
        };
        set_traffic(0, 0);
        foreach (corners[i]) send_value(corners[i]);
        wait_drained();
    endtask

    // Random values under each traffic pattern in turn.
    task automatic test_random_traffic();
        int pattern[4][2];
        pattern = '{'{0, 0}, '{51, 0}, '{0, 51}, '{18, 18}};
        foreach (pattern[p]) begin
            set_traffic(pattern[p][0], pattern[p][1]);
            repeat (RANDOM_PER_PHASE) send_value(random_value());
            wait_drained();
        end
    endtask

    // Receiver holds off for a long stretch while the sender keeps
    // offering back to back, so the internal queue fills and s_ready drops.
    task automatic test_output_backpressure();
        set_traffic(0, 0);
        hold_requests++;
        repeat (16) send_value(random_value());
        wait_drained();
    endtask

    // Receiver: random stalls, plus the long hold-off when one is requested
    always @(posedge aclk) begin
        if (hold_left == 0 && hold_requests != hold_served) begin
            hold_left = HOLD_CYCLES;
            hold_served++;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Checker: each result transaction against the oldest expected character
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            chars_checked++;
            if (pending_chars.size() == 0) begin
                note_failure($sformatf("unexpected char %0d last %0b",
                                       m_ascii_char, m_is_last));
            end else begin
                want_beat = pending_chars.pop_front();
                if (m_ascii_char !== want_beat.ch || m_is_last !== want_beat.last) begin
                    note_failure($sformatf("char exp %0d got %0d, last exp %0b got %0b",
                                           want_beat.ch, m_ascii_char,
                                           want_beat.last, m_is_last));
                end
            end
        end
    end

    // Watchdog: too long without a transaction on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: %0d idle cycles, %0d chars still expected",
                         quiet_cycles, pending_chars.size());
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_corner_values();
        test_random_traffic();
        test_output_backpressure();

        // Catch any stray characters after the last expected one
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pending_chars.size() != 0) begin
            note_failure($sformatf("%0d chars never arrived", pending_chars.size()));
        end

        $display("Converted %0d values (%0d negative) into %0d characters, %0d errors;",
                 values_sent, negatives_sent, chars_checked, failures);
        $display("traffic: back to back, sender gaps, receiver stalls, both, long hold-off.");
        if (failures == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/bdasc_pkg.sv
rtl/bdasc_front.sv
rtl/bdasc_queue.sv
rtl/bdasc_back.sv
rtl/signed_binary_to_decimal_ascii.sv
test/tb_signed_binary_to_decimal_ascii.sv
